// ===== src/ndvi_pkg.sv =====
// Package for the NDVI threshold mask block: register indexes, reset values,
// parameter defaults and result codes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ndvi_pkg;

  // parameter defaults
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF   = 14;

  // configuration port
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_NIR_NODATA = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_NIR_EN     = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_RED_NODATA = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_RED_EN     = 3'd4;

  localparam logic signed [15:0] THRESHOLD_RST = 16'sd8192;  // 0.5 in Q1.14

  // result width and saturation limits
  localparam int NDVI_BITS = 16;
  localparam logic [NDVI_BITS-1:0] SAT_POS = 16'h7FFF;
  localparam logic [NDVI_BITS-1:0] SAT_NEG = 16'h8000;

  // mask byte codes
  localparam logic [7:0] MASK_BELOW   = 8'd0;
  localparam logic [7:0] MASK_ABOVE   = 8'd1;
  localparam logic [7:0] MASK_INVALID = 8'd255;

endpackage

`default_nettype wire

// ===== src/ndvi_threshold_mask.sv =====
// NDVI threshold mask top level: nodata check, pipelined restoring divider,
// saturation and threshold compare. Depends on ndvi_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Takes one pixel (near-infrared and red sample) per cycle, unless a stalled
// output has backed the pipeline up to its input, and returns NDVI =
// (nir - red) / (nir + red) in signed fixed point with FRAC_BITS fraction
// bits, truncated toward zero and saturated to 16 bits, with a valid flag and
// a mask byte (1 at or above threshold, 0 below, 255 for nodata or zero sum).
// Each pixel passes through the front stage, then the divider, which retires
// one quotient bit per pipeline stage, then the output register. A stalled
// output backs up stage by stage, so empty stages keep accepting. Configuration
// writes are always ready and must only be issued while the pipeline is empty.
module ndvi_threshold_mask #(
  parameter int SAMPLE_BITS = ndvi_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = ndvi_pkg::FRAC_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // configuration write
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [ndvi_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  wire logic [ndvi_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  // pixel input
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [SAMPLE_BITS-1:0]             nir_sample_i,
  input  wire logic [SAMPLE_BITS-1:0]             red_sample_i,
  // result output
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic signed [ndvi_pkg::NDVI_BITS-1:0]   ndvi_value_o,
  output logic                                    ndvi_valid_o,
  output logic [7:0]                              mask_byte_o
);

  localparam int S  = SAMPLE_BITS;
  localparam int F  = FRAC_BITS;
  localparam int D  = F + 1;              // divider stages, one quotient bit each
  localparam int RW = S + 2;              // partial remainder width
  localparam int QX = (F + 1 > 17) ? F + 1 : 17;

  typedef struct packed {
    logic         bad;
    logic         neg;
    logic [S:0]   sum;
    logic [RW-1:0] rem;
    logic [F:0]   quo;
  } stg_t;

  // ---------------- configuration registers ----------------
  logic signed [15:0] threshold_q;
  logic [15:0]        nir_nodata_q;
  logic               nir_en_q;
  logic [15:0]        red_nodata_q;
  logic               red_en_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q  <= ndvi_pkg::THRESHOLD_RST;
      nir_nodata_q <= '0;
      nir_en_q     <= 1'b0;
      red_nodata_q <= '0;
      red_en_q     <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ndvi_pkg::REG_THRESHOLD:  threshold_q  <= $signed(cfg_data_i);
        ndvi_pkg::REG_NIR_NODATA: nir_nodata_q <= cfg_data_i;
        ndvi_pkg::REG_NIR_EN:     nir_en_q     <= cfg_data_i[0];
        ndvi_pkg::REG_RED_NODATA: red_nodata_q <= cfg_data_i;
        ndvi_pkg::REG_RED_EN:     red_en_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ---------------- handshake chain ----------------
  // stages 0..D hold stg_t, stage D+1 is the output register
  logic [D+1:0] vld_q;
  logic [D+2:0] rdy;

  assign rdy[D+2] = out_ready_i;

  for (genvar k = 0; k <= D + 1; k++) begin : g_rdy
    assign rdy[k] = !vld_q[k] || rdy[k+1];
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[D+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k <= D + 1; k++) begin
        if (rdy[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // ---------------- front stage: nodata, sum, difference ----------------
  stg_t st_q [D+1];
  stg_t st_d [D+1];

  always_comb begin
    logic nir_bad;
    logic red_bad;
    logic [S-1:0] diff;
    nir_bad = nir_en_q && (nir_sample_i == nir_nodata_q[S-1:0]);
    red_bad = red_en_q && (red_sample_i == red_nodata_q[S-1:0]);
    st_d[0].neg = red_sample_i > nir_sample_i;
    diff = st_d[0].neg ? (red_sample_i - nir_sample_i) : (nir_sample_i - red_sample_i);
    st_d[0].sum = {1'b0, nir_sample_i} + {1'b0, red_sample_i};
    st_d[0].bad = nir_bad || red_bad || (st_d[0].sum == '0);
    st_d[0].rem = RW'(diff);
    st_d[0].quo = '0;
  end

  // ---------------- divider stages ----------------
  // diff <= sum, so the first step yields the integer bit without a shift
  for (genvar j = 1; j <= D; j++) begin : g_div
    localparam int BIT = F - (j - 1);
    logic [RW-1:0] trial;
    logic          take;

    always_comb begin
      trial = (j == 1) ? st_q[j-1].rem : {st_q[j-1].rem[RW-2:0], 1'b0};
      take  = trial >= RW'(st_q[j-1].sum);
      st_d[j]          = st_q[j-1];
      st_d[j].rem      = take ? (trial - RW'(st_q[j-1].sum)) : trial;
      st_d[j].quo[BIT] = take;
    end
  end

  for (genvar k = 0; k <= D; k++) begin : g_stg
    always_ff @(posedge clk_i) begin
      if (rdy[k]) st_q[k] <= st_d[k];
    end
  end

  // ---------------- output stage: saturate, compare ----------------
  logic [QX-1:0]                  q_ext;
  logic signed [ndvi_pkg::NDVI_BITS-1:0] sat_val;
  logic signed [ndvi_pkg::NDVI_BITS-1:0] value_q;
  logic                           valid_q;
  logic [7:0]                     mask_q;

  always_comb begin
    q_ext = QX'(st_q[D].quo);
    if (st_q[D].neg) begin
      sat_val = (q_ext > QX'(ndvi_pkg::SAT_NEG)) ? $signed(ndvi_pkg::SAT_NEG)
                                                 : $signed(-q_ext[15:0]);
    end else begin
      sat_val = (q_ext > QX'(ndvi_pkg::SAT_POS)) ? $signed(ndvi_pkg::SAT_POS)
                                                 : $signed(q_ext[15:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[D+1]) begin
      if (st_q[D].bad) begin
        value_q <= '0;
        valid_q <= 1'b0;
        mask_q  <= ndvi_pkg::MASK_INVALID;
      end else begin
        value_q <= sat_val;
        valid_q <= 1'b1;
        mask_q  <= (sat_val >= threshold_q) ? ndvi_pkg::MASK_ABOVE : ndvi_pkg::MASK_BELOW;
      end
    end
  end

  assign ndvi_value_o = value_q;
  assign ndvi_valid_o = valid_q;
  assign mask_byte_o  = mask_q;

endmodule

`default_nettype wire

// ===== bench/tb_ndvi_threshold_mask.sv =====
// Testbench for ndvi_threshold_mask: directed and random pixel traffic, register
// writes between phases, and a scoreboard that checks every result in order.
// Depends on ndvi_pkg and ndvi_threshold_mask.
`timescale 1ns / 1ps

module tb_ndvi_threshold_mask;

  localparam int PIPE_LATENCY = ndvi_pkg::FRAC_BITS_DEF + 3;
  localparam int STALL_LIMIT  = 2000;
  localparam int RAND_PHASES  = 9;
  localparam int PHASE_PIXELS = 150;

  typedef struct packed {
    logic signed [ndvi_pkg::NDVI_BITS-1:0] value;
    logic                                  valid;
    logic [7:0]                            mask;
  } ndvi_result_t;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;

  logic                               cfg_valid = 1'b0;
  logic [ndvi_pkg::CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [ndvi_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;
  logic                               in_valid = 1'b0;
  logic [15:0]                        nir_sample = '0;
  logic [15:0]                        red_sample = '0;
  logic                               out_ready = 1'b0;

  wire logic                                  cfg_ready_o;
  wire logic                                  in_ready_o;
  wire logic                                  out_valid_o;
  wire logic signed [ndvi_pkg::NDVI_BITS-1:0] ndvi_value_o;
  wire logic                                  ndvi_valid_o;
  wire logic [7:0]                            mask_byte_o;

  // shadow copy of the register file
  logic signed [15:0] ndvi_threshold = ndvi_pkg::THRESHOLD_RST;
  logic [15:0]        nir_nodata_val = '0;
  logic               nir_nodata_en = 1'b0;
  logic [15:0]        red_nodata_val = '0;
  logic               red_nodata_en = 1'b0;

  ndvi_result_t pixel_results_q[$];
  bit           gaps_on = 1'b1;
  int           errors = 0;
  int           pixels_sent = 0;
  int           invalid_pixels = 0;
  int           results_checked = 0;
  int           config_writes = 0;
  int           stalled_cycles = 0;

  ndvi_threshold_mask u_top (
    .clk_i        (clk),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready_o),
    .nir_sample_i (nir_sample),
    .red_sample_i (red_sample),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready),
    .ndvi_value_o (ndvi_value_o),
    .ndvi_valid_o (ndvi_valid_o),
    .mask_byte_o  (mask_byte_o)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // expected result of one pixel under the current register settings
  function automatic ndvi_result_t ndvi_of_pixel(input logic [15:0] nir,
                                                 input logic [15:0] red);
    ndvi_result_t r;
    logic [16:0]  total;
    logic [15:0]  delta;
    longint       quot;
    bit           negative;
    r = '{value: '0, valid: 1'b0, mask: ndvi_pkg::MASK_INVALID};
    if ((nir_nodata_en && nir == nir_nodata_val) ||
        (red_nodata_en && red == red_nodata_val) ||
        (nir == 16'd0 && red == 16'd0))
      return r;
    total    = nir + red;
    negative = red > nir;
    delta    = negative ? red - nir : nir - red;
    quot     = (longint'(delta) << ndvi_pkg::FRAC_BITS_DEF) / longint'(total);
    // truncate toward zero on magnitude, then saturate to 16 bits
    if (negative) begin
      quot = (quot > 32768) ? -32768 : -quot;
    end else if (quot > 32767) begin
      quot = 32767;
    end
    r.value = quot[15:0];
    r.valid = 1'b1;
    r.mask  = (quot >= longint'(ndvi_threshold)) ? ndvi_pkg::MASK_ABOVE
                                                 : ndvi_pkg::MASK_BELOW;
    return r;
  endfunction

  task automatic push_pixel(input logic [15:0] nir, input logic [15:0] red);
    ndvi_result_t r;
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    nir_sample <= nir;
    red_sample <= red;
    @(posedge clk);
    while (!in_ready_o) @(posedge clk);
    r = ndvi_of_pixel(nir, red);
    pixel_results_q = {pixel_results_q, r};
    pixels_sent++;
    if (!r.valid) invalid_pixels++;
  endtask

  // valid stays high across back-to-back writes; lowered after the last one
  task automatic cfg_write(input logic [ndvi_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [15:0] data, input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready_o) @(posedge clk);
    case (idx)
      ndvi_pkg::REG_THRESHOLD:  ndvi_threshold = data;
      ndvi_pkg::REG_NIR_NODATA: nir_nodata_val = data;
      ndvi_pkg::REG_NIR_EN:     nir_nodata_en = data[0];
      ndvi_pkg::REG_RED_NODATA: red_nodata_val = data;
      ndvi_pkg::REG_RED_EN:     red_nodata_en = data[0];
      default: ;
    endcase
    config_writes++;
    if (last) cfg_valid <= 1'b0;
  endtask

  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (pixel_results_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // enable registers get random upper bits; only bit 0 counts
  task automatic set_config(input logic signed [15:0] thr, input logic [15:0] nir_nd,
                            input bit nir_en, input logic [15:0] red_nd, input bit red_en);
    drain_pipeline();
    cfg_write(ndvi_pkg::REG_THRESHOLD, thr, 1'b0);
    cfg_write(ndvi_pkg::REG_NIR_NODATA, nir_nd, 1'b0);
    cfg_write(ndvi_pkg::REG_NIR_EN, {15'($urandom), nir_en}, 1'b0);
    cfg_write(ndvi_pkg::REG_RED_NODATA, red_nd, 1'b0);
    cfg_write(ndvi_pkg::REG_RED_EN, {15'($urandom), red_en}, 1'b1);
  endtask

  task automatic test_reset_defaults();
    push_pixel(16'd0, 16'd0);          // zero sum
    push_pixel(16'hFFFF, 16'd0);       // +1.0
    push_pixel(16'd0, 16'hFFFF);       // -1.0
    push_pixel(16'hFFFF, 16'hFFFF);    // zero difference
    push_pixel(16'd3, 16'd1);          // exactly 0.5, at threshold
    push_pixel(16'd30001, 16'd10000);  // just over 0.5, truncates to exactly 0.5
    push_pixel(16'd1, 16'd2);          // negative truncates toward zero
    push_pixel(16'hFFFF, 16'hFFFE);
  endtask

  task automatic test_nodata();
    set_config(16'sd0, 16'h1234, 1'b1, 16'hFFFF, 1'b1);
    push_pixel(16'h1234, 16'd5);
    push_pixel(16'd5, 16'hFFFF);
    push_pixel(16'h1234, 16'hFFFF);
    push_pixel(16'h1235, 16'hFFFE);
    push_pixel(16'd0, 16'd0);
    // nodata value zero on nir only, red check disabled
    set_config(16'sd0, 16'h0000, 1'b1, 16'hFFFF, 1'b0);
    push_pixel(16'd0, 16'd100);
    push_pixel(16'd100, 16'hFFFF);
  endtask

  task automatic test_threshold_extremes();
    set_config(-16'sd16384, 16'h0000, 1'b0, 16'h0000, 1'b0);
    push_pixel(16'd0, 16'hFFFF);
    push_pixel(16'd1, 16'd2);
    set_config(16'sd16384, 16'h0000, 1'b0, 16'h0000, 1'b0);
    push_pixel(16'hFFFF, 16'd0);
    push_pixel(16'hFFFF, 16'd1);
    set_config(-16'sd32768, 16'hFFFF, 1'b1, 16'h0000, 1'b1);
    push_pixel(16'd0, 16'd7);
    push_pixel(16'd9, 16'd4);
    set_config(16'sd32767, 16'hFFFF, 1'b1, 16'h0000, 1'b1);
    push_pixel(16'd1, 16'd0);
    push_pixel(16'hFFFE, 16'd3);
  endtask

  task automatic test_unknown_index();
    drain_pipeline();
    for (int i = int'(ndvi_pkg::REG_RED_EN) + 1; i < (1 << ndvi_pkg::CFG_IDX_BITS); i++)
      cfg_write(ndvi_pkg::CFG_IDX_BITS'(i), 16'($urandom),
                i == (1 << ndvi_pkg::CFG_IDX_BITS) - 1);
    push_pixel(16'hFFFF, 16'd9);
    push_pixel(16'd12, 16'd1000);
  endtask

  task automatic test_random_traffic();
    logic signed [15:0] thr;
    logic [15:0]        nir;
    logic [15:0]        red;
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: thr = -16'sd16384;
        1: thr = 16'sd16384;
        2: thr = -16'sd32768;
        3: thr = 16'sd32767;
        4: thr = 16'sd0;
        default: thr = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 32768) - 16384);
      endcase
      if (p == 0)
        set_config(thr, 16'h0000, 1'b1, 16'hFFFF, 1'b1);
      else
        set_config(thr, 16'($urandom), 1'($urandom), 16'($urandom), 1'($urandom));
      // last phase runs at full rate on both sides
      gaps_on = (p == RAND_PHASES - 1) ? 1'b0 : ($urandom_range(0, 2) != 0);
      for (int k = 0; k < PHASE_PIXELS; k++) begin
        nir = 16'($urandom);
        red = 16'($urandom);
        case ($urandom_range(0, 9))
          0: nir = nir_nodata_val;
          1: red = red_nodata_val;
          2: begin
            nir = 16'd0;
            red = 16'($urandom_range(0, 1));
          end
          3: begin
            nir = 16'($urandom_range(0, 15));
            red = 16'($urandom_range(0, 15));
          end
          4: red = nir + 16'($urandom_range(0, 4)) - 16'd2;
          5: begin
            nir = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            red = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(0, 3));
          end
          default: ;
        endcase
        push_pixel(nir, red);
      end
    end
  endtask

  // output stall bursts
  always begin
    @(posedge clk);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    out_ready <= 1'b1;
  end

  always @(posedge clk) begin
    ndvi_result_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      results_checked++;
      if (pixel_results_q.size() == 0) begin
        $error("unexpected result transaction: ndvi_value %0d", ndvi_value_o);
        errors++;
      end else begin
        want = pixel_results_q.pop_front();
        if (ndvi_value_o !== want.value) begin
          $error("ndvi_value: expected %0d, got %0d", want.value, ndvi_value_o);
          errors++;
        end
        if (ndvi_valid_o !== want.valid) begin
          $error("ndvi_valid: expected %0d, got %0d", want.valid, ndvi_valid_o);
          errors++;
        end
        if (mask_byte_o !== want.mask) begin
          $error("mask_byte: expected %0d, got %0d", want.mask, mask_byte_o);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_ni || (in_valid && in_ready_o) || (out_valid_o && out_ready) ||
        (cfg_valid && cfg_ready_o)) begin
      stalled_cycles = 0;
    end else begin
      stalled_cycles++;
      if (stalled_cycles >= STALL_LIMIT) begin
        $display("FAIL ndvi_threshold_mask");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_nodata();
    test_threshold_extremes();
    test_unknown_index();
    test_random_traffic();
    drain_pipeline();
    repeat (PIPE_LATENCY + 4) @(posedge clk);
    if (pixel_results_q.size() != 0) begin
      $error("%0d results never arrived", pixel_results_q.size());
      errors++;
    end
    $display("Sent %0d pixels (%0d invalid) across %0d register writes; checked %0d results.",
             pixels_sent, invalid_pixels, config_writes, results_checked);
    if (errors == 0) begin
      $display("PASS ndvi_threshold_mask");
    end else begin
      $display("FAIL ndvi_threshold_mask");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/ndvi_pkg.sv
src/ndvi_threshold_mask.sv
bench/tb_ndvi_threshold_mask.sv
